@@ sv/isu_pkg.sv @@
// shared types and codes for the indexed sequence store
`timescale 1ns / 1ps
`default_nettype none
package isu_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 5;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT_AT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_REMOVE_AT  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_READ_AT    = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	// operation that every cell performs under the broadcast command
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [STAT_W-1:0]   status;
		logic                rd_en;
	} isu_cmd_t;

endpackage
`default_nettype wire

@@ sv/isu_cell.sv @@
// one storage cell of the list, shifting with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module isu_cell #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  wire logic                      clk,
	input  wire isu_pkg::cell_op_t         op,
	input  wire logic [CW-1:0]             at,
	input  wire logic [isu_pkg::DATA_W-1:0] word,
	input  wire logic [isu_pkg::DATA_W-1:0] left,
	input  wire logic [isu_pkg::DATA_W-1:0] right,
	output logic      [isu_pkg::DATA_W-1:0] data,
	output logic      [isu_pkg::DATA_W-1:0] sel_data
);
	import isu_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_OPEN: begin
				if (MY_IDX == at) begin
					data_q <= word;
				end else if (MY_IDX > at) begin
					data_q <= left;
				end
			end
			CELL_CLOSE: begin
				if (MY_IDX >= at) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data     = data_q;
	// only the addressed cell drives the read bus
	assign sel_data = (MY_IDX == at) ? data_q : '0;

endmodule
`default_nettype wire

@@ sv/isu_ctrl.sv @@
// action decode: cell command, status and next count
`timescale 1ns / 1ps
`default_nettype none
module isu_ctrl #(
	parameter int DEPTH = isu_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic [isu_pkg::ACT_W-1:0] action,
	input  wire logic [isu_pkg::POS_W-1:0] position,
	input  wire logic [CW-1:0]             count,
	output isu_pkg::isu_cmd_t              cmd,
	output logic      [CW-1:0]             at,
	output logic      [CW-1:0]             count_nxt
);
	import isu_pkg::*;

	localparam int EW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [EW-1:0] pos_ext;
	logic [EW-1:0] cnt_ext;
	logic          pos_oor;
	logic          full;
	logic          empty;

	assign pos_ext = EW'(position);
	assign cnt_ext = EW'(count);
	assign pos_oor = pos_ext >= cnt_ext;
	assign full    = count == FULL_CNT;
	assign empty   = count == '0;

	always_comb begin
		cmd.op     = CELL_HOLD;
		cmd.status = STAT_OK;
		cmd.rd_en  = 1'b0;
		at         = '0;
		count_nxt  = count;
		unique case (action)
			ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
				if (full) begin
					cmd.status = STAT_FULL;
				end else begin
					cmd.op    = CELL_OPEN;
					count_nxt = count + CW'(1);
					if (action == ACT_PUSH_FRONT) begin
						at = '0;
					end else if (action == ACT_PUSH_BACK || pos_oor) begin
						at = count;
					end else begin
						at = pos_ext[CW-1:0];
					end
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (empty) begin
					cmd.status = STAT_EMPTY;
				end else begin
					cmd.op    = CELL_CLOSE;
					count_nxt = count - CW'(1);
					at        = (action == ACT_POP_FRONT) ? '0 : count - CW'(1);
				end
			end
			ACT_REMOVE_AT: begin
				if (empty) begin
					cmd.status = STAT_EMPTY;
				end else if (pos_oor) begin
					cmd.status = STAT_RANGE;
				end else begin
					cmd.op    = CELL_CLOSE;
					count_nxt = count - CW'(1);
					at        = pos_ext[CW-1:0];
				end
			end
			ACT_READ_AT: begin
				if (pos_oor) begin
					cmd.status = STAT_RANGE;
				end else begin
					cmd.rd_en = 1'b1;
					at        = pos_ext[CW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/indexed_sequence_store_unit.sv @@
// top level: bounded ordered list of signed words kept in a row of shifting cells
//
// cmd channel (cmd_valid / cmd_stall) brings one word per action: action, value
// and position. rsp channel (rsp_valid / rsp_stall) returns exactly one word per
// action: read_value, element_count and status.
// every action finishes in the cycle it is accepted: all cells shift left or
// right together under one broadcast command, so inserts and removes at any
// position cost the same. the response appears in the output register in
// the cycle after acceptance; a new action can be taken every unstalled cycle.
// when the receiver stalls, the pending response is held and cmd_stall rises,
// so no action is taken until the response register frees up (it frees in the
// same cycle the response is taken).
// reset (arst_n low) empties the list and drops any pending response; the cell
// contents are not cleared, since only words below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module indexed_sequence_store_unit #(
	parameter int DEPTH = isu_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_valid,
	output logic                                  cmd_stall,
	input  wire logic        [isu_pkg::ACT_W-1:0]  action,
	input  wire logic signed [isu_pkg::DATA_W-1:0] value,
	input  wire logic        [isu_pkg::POS_W-1:0]  position,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic signed      [isu_pkg::DATA_W-1:0] read_value,
	output logic             [isu_pkg::POS_W-1:0]  element_count,
	output logic             [isu_pkg::STAT_W-1:0] status
);
	import isu_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > POS_W) ? CW : POS_W;

	// list length and response register
	logic [CW-1:0]     count_q;
	logic              rsp_valid_q;
	logic [DATA_W-1:0] read_value_q;
	logic [POS_W-1:0]  element_count_q;
	logic [STAT_W-1:0] status_q;

	isu_cmd_t          cmd;
	logic [CW-1:0]     at;
	logic [CW-1:0]     count_nxt;
	logic [EW-1:0]     count_nxt_ext;
	logic              accept;
	cell_op_t          cell_op;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_sel  [DEPTH];
	logic [DATA_W-1:0] rd_bus;

	// the response register frees when its word is taken
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;

	isu_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.action    (action),
		.position  (position),
		.count     (count_q),
		.cmd       (cmd),
		.at        (at),
		.count_nxt (count_nxt)
	);

	// cells only move on an accepted action
	assign cell_op = accept ? cmd.op : CELL_HOLD;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		isu_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.op       (cell_op),
			.at       (at),
			.word     (value),
			.left     (left_w),
			.right    (right_w),
			.data     (cell_data[i]),
			.sel_data (cell_sel[i])
		);
	end

	// read bus: each cell contributes only when addressed
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_bus = rd_bus | cell_sel[i];
		end
	end

	assign count_nxt_ext = EW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q    <= cmd.rd_en ? rd_bus : '0;
			element_count_q <= count_nxt_ext[POS_W-1:0];
			status_q        <= cmd.status;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign read_value    = read_value_q;
	assign element_count = element_count_q;
	assign status        = status_q;

endmodule
`default_nettype wire

@@ tb/tb_indexed_sequence_store_unit.sv @@
// self-checking testbench for the indexed sequence store unit
`timescale 1ns / 1ps
module tb_indexed_sequence_store_unit;
	import isu_pkg::*;

	localparam int LIST_DEPTH   = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int DRAIN_AT     = 700;     // sender waits for every reply before this word
	localparam int HOLD_AFTER   = 300;     // replies taken before the long receiver hold
	localparam int LONG_HOLD    = 80;      // cycles of that hold
	localparam int SETTLE       = 10;      // slack before the final check for missing replies
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PRINT_CAP    = 200;

	// the action code the package leaves unused; the block must treat it as a no-op
	localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

	typedef struct {
		logic        [ACT_W-1:0]  action;
		logic signed [DATA_W-1:0] value;
		logic        [POS_W-1:0]  position;
		bit                       drain_first;
	} list_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0] read_value;
		logic        [POS_W-1:0]  element_count;
		logic        [STAT_W-1:0] status;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [ACT_W-1:0] action = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0] position = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0] element_count;
	logic [STAT_W-1:0] status;

	// stimulus waiting to be offered, and replies the block still owes
	list_cmd_t   pending_cmds[$];
	list_reply_t expected_replies[$];

	// mirror of the list contents, advanced once per accepted command word
	logic signed [DATA_W-1:0] mirror_words[LIST_DEPTH];
	int unsigned mirror_count = 0;

	int unsigned gen_count = 0;    // list length as the generator sees it
	int errors = 0;
	int unsigned cycle_count = 0;

	// driver and receiver bookkeeping
	int unsigned gap_left;
	int unsigned cmds_sent;
	int in_flight;
	int unsigned stall_left;
	int unsigned rsp_taken;
	bit long_hold_done;

	indexed_sequence_store_unit #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.action(action),
		.value(value),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.read_value(read_value),
		.element_count(element_count),
		.status(status)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// close the hole left at index at by shifting later words down
	function automatic void drop_word(input int unsigned at);
		for (int unsigned i = at; i + 1 < mirror_count; i++)
			mirror_words[i] = mirror_words[i + 1];
		mirror_count--;
	endfunction

	// apply one action to the mirrored list and return the reply word it owes
	function automatic list_reply_t apply_list_action(input logic [ACT_W-1:0] act,
			input logic signed [DATA_W-1:0] word, input logic [POS_W-1:0] pos);
		list_reply_t r;
		int unsigned at;
		r.read_value = '0;
		r.status = STAT_OK;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
				if (mirror_count >= LIST_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					// an insert past the end lands at the back
					if (act == ACT_PUSH_FRONT)
						at = 0;
					else if (act == ACT_PUSH_BACK || pos >= mirror_count)
						at = mirror_count;
					else
						at = pos;
					for (int unsigned i = mirror_count; i > at; i--)
						mirror_words[i] = mirror_words[i - 1];
					mirror_words[at] = word;
					mirror_count++;
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (mirror_count == 0)
					r.status = STAT_EMPTY;
				else
					drop_word(act == ACT_POP_FRONT ? 0 : mirror_count - 1);
			end
			ACT_REMOVE_AT: begin
				if (mirror_count == 0)
					r.status = STAT_EMPTY;
				else if (pos >= mirror_count)
					r.status = STAT_RANGE;
				else
					drop_word(pos);
			end
			ACT_READ_AT: begin
				if (pos >= mirror_count)
					r.status = STAT_RANGE;
				else
					r.read_value = mirror_words[pos];
			end
			default: begin
				// unused code: list untouched, plain ok
			end
		endcase
		r.element_count = POS_W'(mirror_count);
		return r;
	endfunction

	// queue one command word and track the length the list will have after it
	task automatic add_cmd(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] word,
			input logic [POS_W-1:0] pos, input bit drain);
		list_cmd_t item;
		item.action = act;
		item.value = word;
		item.position = pos;
		item.drain_first = drain;
		pending_cmds.insert(pending_cmds.size(), item);
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
				if (gen_count < LIST_DEPTH)
					gen_count++;
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (gen_count != 0)
					gen_count--;
			end
			ACT_REMOVE_AT: begin
				if (pos < gen_count)
					gen_count--;
			end
			default: begin
			end
		endcase
	endtask

	// command driver: offers queued words with random gaps, holds a stalled word
	// steady, and before a drain-marked word waits until every reply is back
	always @(posedge clk or negedge arst_n) begin
		list_cmd_t cur;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			action <= ACT_PUSH_FRONT;
			value <= '0;
			position <= '0;
			gap_left <= 0;
			cmds_sent <= 0;
			in_flight <= 0;
		end else begin
			in_flight <= in_flight + int'(cmd_valid && !cmd_stall) - int'(rsp_valid && !rsp_stall);
			if (!(cmd_valid && cmd_stall)) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() != 0 && (!pending_cmds[0].drain_first
						|| (!cmd_valid && in_flight == int'(rsp_valid && !rsp_stall)))) begin
					cur = pending_cmds[0];
					pending_cmds.delete(0);
					cmd_valid <= 1'b1;
					action <= cur.action;
					value <= cur.value;
					position <= cur.position;
					cmds_sent <= cmds_sent + 1;
					// every third stretch of 200 words goes back to back
					gap_left <= ((cmds_sent / 200) % 3 == 1) ? 0 : pick_gap();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// reply receiver: random stalls, calm stretches, and one long hold mid-run
	// that backs the block up until it stalls its command side
	always @(posedge clk or negedge arst_n) begin
		int unsigned len;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
			rsp_taken <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				rsp_taken <= rsp_taken + 1;
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_stall <= 1'b1;
			end else if (!long_hold_done && rsp_taken >= HOLD_AFTER) begin
				long_hold_done <= 1'b1;
				rsp_stall <= 1'b1;
				stall_left <= LONG_HOLD - 1;
			end else if ((rsp_taken / 250) % 3 == 2) begin
				rsp_stall <= 1'b0;
			end else begin
				len = pick_gap();
				if (len == 0) begin
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= 1'b1;
					stall_left <= len - 1;
				end
			end
		end
	end

	// monitor: check the reply taken at this edge first, then predict the reply
	// for the command taken at this edge, so a reply can never match its own command
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display("%0t unexpected reply: value %0d count %0d status %0d",
							$time, read_value, element_count, status);
				end else begin
					want = expected_replies[0];
					expected_replies.delete(0);
					if (read_value !== want.read_value || element_count !== want.element_count
							|| status !== want.status) begin
						errors++;
						if (errors <= PRINT_CAP)
							$display({"%0t mismatch: expected value %0d count %0d status %0d,",
								" got value %0d count %0d status %0d"},
								$time, want.read_value, want.element_count, want.status,
								read_value, element_count, status);
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				expected_replies.insert(expected_replies.size(),
					apply_list_action(action, value, position));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;
		int unsigned mood;
		int unsigned roll;

		// directed: every failure on an empty list, the unused code
		add_cmd(ACT_READ_AT, '0, 5'd0, 1'b0);
		add_cmd(ACT_POP_FRONT, '0, 5'd0, 1'b0);
		add_cmd(ACT_POP_BACK, '0, 5'd0, 1'b0);
		add_cmd(ACT_REMOVE_AT, '0, 5'd0, 1'b0);
		add_cmd(ACT_UNUSED, 32'sh12345678, 5'd3, 1'b0);
		// fill to the top with extreme words, one insert far past the end
		for (int k = 0; k < LIST_DEPTH; k++) begin
			case (k % 3)
				0: act = ACT_PUSH_BACK;
				1: act = ACT_PUSH_FRONT;
				default: act = ACT_INSERT_AT;
			endcase
			pos = (k == 2) ? 5'd16 : POS_W'(k / 2);
			case (k)
				0: add_cmd(act, 32'sh7fffffff, pos, 1'b0);
				1: add_cmd(act, 32'sh80000000, pos, 1'b0);
				2: add_cmd(act, -32'sd1, pos, 1'b0);
				3: add_cmd(act, '0, pos, 1'b0);
				default: add_cmd(act, $urandom, pos, 1'b0);
			endcase
		end
		// full store, last valid read, reads and removes just past the end
		add_cmd(ACT_PUSH_BACK, 32'sh0badf00d, 5'd0, 1'b0);
		add_cmd(ACT_INSERT_AT, 32'sh55555555, 5'd3, 1'b0);
		add_cmd(ACT_READ_AT, '0, 5'd15, 1'b0);
		add_cmd(ACT_READ_AT, '0, 5'd16, 1'b0);
		add_cmd(ACT_REMOVE_AT, '0, 5'd16, 1'b0);

		// random: stretches that grow, shrink, or mix, so the list keeps
		// hitting both full and empty
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mood = (n / 150) % 3;
			roll = $urandom_range(0, 99);
			if (roll == 0)
				act = ACT_UNUSED;
			else if (mood == 0)
				act = ACT_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 2)
					: $urandom_range(3, 6));
			else if (mood == 1)
				act = ACT_W'(($urandom_range(0, 99) < 25) ? $urandom_range(0, 2)
					: $urandom_range(3, 6));
			else
				act = ACT_W'($urandom_range(0, 6));
			// positions mostly inside the list, some anywhere in range
			if (gen_count == 0 || $urandom_range(0, 4) == 0)
				pos = POS_W'($urandom_range(0, 16));
			else if (act == ACT_INSERT_AT)
				pos = POS_W'($urandom_range(0, gen_count));
			else
				pos = POS_W'($urandom_range(0, gen_count - 1));
			add_cmd(act, pick_word(), pos, n == DRAIN_AT);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || in_flight != 0);
		repeat (SETTLE) @(negedge clk);
		if (expected_replies.size() != 0) begin
			errors++;
			$display("%0t %0d expected reply words never arrived", $time, expected_replies.size());
		end
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
